[hdl/i2cms_pkg.sv]
// Package for the I2C master transfer sequencer.
// Holds item kinds, bus status codes, progress codes and the result record.
// No dependencies.
`default_nettype none

package i2cms_pkg;

	localparam int MAX_MESSAGE_DEF = 32;

	localparam logic [1:0] KIND_LOAD   = 2'd0;
	localparam logic [1:0] KIND_BEGIN  = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [3:0] ST_START       = 4'd0;
	localparam logic [3:0] ST_RESTART     = 4'd1;
	localparam logic [3:0] ST_TXADDR_ACK  = 4'd2;
	localparam logic [3:0] ST_TXDATA_ACK  = 4'd3;
	localparam logic [3:0] ST_RXDATA_ACK  = 4'd4;
	localparam logic [3:0] ST_RXADDR_ACK  = 4'd5;
	localparam logic [3:0] ST_RXDATA_NACK = 4'd6;
	localparam logic [3:0] ST_OTHER       = 4'd11;

	localparam logic [1:0] PROG_IDLE = 2'd0;
	localparam logic [1:0] PROG_BUSY = 2'd1;
	localparam logic [1:0] PROG_OK   = 2'd2;
	localparam logic [1:0] PROG_ERR  = 2'd3;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       tx_load;
		logic       go_start;
		logic       go_stop;
		logic       send_ack;
		logic       irq_enable;
		logic       clear_flag;
		logic [1:0] xfer_state;
		logic [3:0] fault_code;
		logic [7:0] rx_byte;
		logic       rx_store;
	} result_t;

endpackage

`default_nettype wire

[hdl/i2cms_msg_buffer.sv]
// Message byte buffer for the I2C master transfer sequencer.
// One write port and one read port with registered read data; no dependencies.
`default_nettype none

module i2cms_msg_buffer #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[hdl/i2c_master_transfer_sequencer.sv]
// I2C master transfer sequencer, top level; uses i2cms_pkg and i2cms_msg_buffer.
// Each result is registered: it appears on the master side in the cycle after its input transaction is accepted.
// Throughput: one item per cycle; the result register and the buffer read port
// advance together, so an item is taken whenever the result register is empty or drains.
// Reset: arst_n clears the indexes, length, progress, fault code, address register
// and result valid at once; the message buffer is not cleared.
`default_nettype none

module i2c_master_transfer_sequencer
	import i2cms_pkg::*;
#(
	parameter int MAX_MESSAGE = MAX_MESSAGE_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // data_byte[7:0], message_length[13:8], bus_status[17:14]
	input  wire logic [1:0]  s_tuser,  // kind[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [31:0] m_tdata   // tx_byte[7:0], tx_load[8], go_start[9], go_stop[10],
	                                   // send_ack[11], irq_enable[12], clear_flag[13],
	                                   // xfer_state[15:14], fault_code[19:16],
	                                   // rx_byte[27:20], rx_store[28]
);

	localparam int CW = $clog2(MAX_MESSAGE + 1);
	localparam int AW = (MAX_MESSAGE > 1) ? $clog2(MAX_MESSAGE) : 1;
	localparam int XW = ((CW > 6) ? CW : 6) + 1;
	localparam logic [CW-1:0] MAX_C = CW'(MAX_MESSAGE);

	logic [CW-1:0] bidx_q, load_ptr_q, len_q;
	logic [CW-1:0] bidx_d, load_ptr_d, len_d;
	logic [1:0]    prog_q, prog_d;
	logic [3:0]    fault_q, fault_d;
	logic [7:0]    addr_q;

	logic          accept;
	logic [1:0]    kind;
	logic [7:0]    data_byte;
	logic [5:0]    message_length;
	logic [3:0]    bus_status;

	result_t       res_d, res_s1;
	logic          tx_mem_d, tx_mem_s1;
	logic          valid_s1;

	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    wdata, rdata;

	assign kind           = s_tuser;
	assign data_byte      = s_tdata[7:0];
	assign message_length = s_tdata[13:8];
	assign bus_status     = s_tdata[17:14];

	assign cfg_ready = 1'b1;
	assign s_tready  = !valid_s1 || m_tready;
	assign accept    = s_tvalid && s_tready;

	always_comb begin
		bidx_d     = bidx_q;
		load_ptr_d = load_ptr_q;
		len_d      = len_q;
		prog_d     = prog_q;
		fault_d    = fault_q;
		res_d      = '0;
		tx_mem_d   = 1'b0;
		we         = 1'b0;
		waddr      = load_ptr_q[AW-1:0];
		wdata      = data_byte;
		re         = 1'b0;
		raddr      = bidx_q[AW-1:0];
		case (kind)
			KIND_LOAD: begin
				if (load_ptr_q < MAX_C) begin
					we         = 1'b1;
					load_ptr_d = load_ptr_q + 1'b1;
				end
			end
			KIND_BEGIN: begin
				if (XW'(message_length) > XW'(MAX_MESSAGE)) begin
					len_d = MAX_C;
				end else begin
					len_d = CW'(message_length);
				end
				load_ptr_d       = '0;
				prog_d           = PROG_BUSY;
				res_d.go_start   = 1'b1;
				res_d.irq_enable = 1'b1;
				res_d.clear_flag = 1'b1;
			end
			KIND_STATUS: begin
				case (bus_status)
					ST_START, ST_RESTART: begin
						bidx_d           = '0;
						res_d.tx_byte    = addr_q;
						res_d.tx_load    = 1'b1;
						res_d.irq_enable = 1'b1;
						res_d.clear_flag = 1'b1;
					end
					ST_TXADDR_ACK, ST_TXDATA_ACK: begin
						if (bidx_q < len_q && bidx_q < MAX_C) begin
							re               = 1'b1;
							tx_mem_d         = 1'b1;
							bidx_d           = bidx_q + 1'b1;
							res_d.tx_load    = 1'b1;
							res_d.irq_enable = 1'b1;
							res_d.clear_flag = 1'b1;
						end else begin
							prog_d           = PROG_OK;
							res_d.go_stop    = 1'b1;
							res_d.clear_flag = 1'b1;
						end
					end
					ST_RXDATA_ACK, ST_RXADDR_ACK: begin
						if (bus_status == ST_RXDATA_ACK && bidx_q < MAX_C) begin
							we             = 1'b1;
							waddr          = bidx_q[AW-1:0];
							res_d.rx_byte  = data_byte;
							res_d.rx_store = 1'b1;
							bidx_d         = bidx_q + 1'b1;
						end
						res_d.send_ack   = ((CW + 1)'(bidx_d) + 1'b1) < (CW + 1)'(len_q);
						res_d.irq_enable = 1'b1;
						res_d.clear_flag = 1'b1;
					end
					ST_RXDATA_NACK: begin
						if (bidx_q < MAX_C) begin
							we             = 1'b1;
							waddr          = bidx_q[AW-1:0];
							res_d.rx_byte  = data_byte;
							res_d.rx_store = 1'b1;
						end
						prog_d           = PROG_OK;
						res_d.go_stop    = 1'b1;
						res_d.clear_flag = 1'b1;
					end
					default: begin
						prog_d  = PROG_ERR;
						fault_d = (bus_status > ST_OTHER) ? ST_OTHER : bus_status;
					end
				endcase
			end
			default: begin
			end
		endcase
		res_d.xfer_state = prog_d;
		res_d.fault_code = fault_d;
	end

	i2cms_msg_buffer #(
		.DEPTH(MAX_MESSAGE),
		.AW   (AW)
	) u_buffer (
		.clk  (clk),
		.we   (accept && we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (accept && re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bidx_q     <= '0;
			load_ptr_q <= '0;
			len_q      <= '0;
			prog_q     <= PROG_IDLE;
			fault_q    <= '0;
			addr_q     <= '0;
			valid_s1   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				addr_q <= cfg_data;
			end
			if (accept) begin
				bidx_q     <= bidx_d;
				load_ptr_q <= load_ptr_d;
				len_q      <= len_d;
				prog_q     <= prog_d;
				fault_q    <= fault_d;
				valid_s1   <= 1'b1;
			end else if (m_tready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1    <= res_d;
			tx_mem_s1 <= tx_mem_d;
		end
	end

	assign m_tvalid        = valid_s1;
	assign m_tdata[7:0]    = tx_mem_s1 ? rdata : res_s1.tx_byte;
	assign m_tdata[8]      = res_s1.tx_load;
	assign m_tdata[9]      = res_s1.go_start;
	assign m_tdata[10]     = res_s1.go_stop;
	assign m_tdata[11]     = res_s1.send_ack;
	assign m_tdata[12]     = res_s1.irq_enable;
	assign m_tdata[13]     = res_s1.clear_flag;
	assign m_tdata[15:14]  = res_s1.xfer_state;
	assign m_tdata[19:16]  = res_s1.fault_code;
	assign m_tdata[27:20]  = res_s1.rx_byte;
	assign m_tdata[28]     = res_s1.rx_store;
	assign m_tdata[31:29]  = 3'b000;

endmodule

`default_nettype wire

[tb/i2cms_checker.sv]
// Checker for the I2C master transfer sequencer: watches the address write, input and result
// channels, predicts each result from its own copy of the sequencer state and compares them.
// Depends on i2cms_pkg for item kinds, bus status codes, progress codes and result_t.

module i2cms_checker
	import i2cms_pkg::*;
#(
	parameter int MAX_MESSAGE = MAX_MESSAGE_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [23:0] s_tdata,  // data_byte[7:0], message_length[13:8], bus_status[17:14]
	input  wire logic [1:0]  s_tuser,  // kind[1:0]
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [31:0] m_tdata,  // tx_byte[7:0], tx_load[8], go_start[9], go_stop[10],
	                                   // send_ack[11], irq_enable[12], clear_flag[13],
	                                   // xfer_state[15:14], fault_code[19:16],
	                                   // rx_byte[27:20], rx_store[28]
	output int               pending,
	output int               fails
);

	localparam int AW = (MAX_MESSAGE > 1) ? $clog2(MAX_MESSAGE) : 1;

	logic [7:0] msg_mem [MAX_MESSAGE];
	logic [5:0] rd_idx;
	logic [5:0] wr_ptr;
	logic [5:0] xfer_len;
	logic [1:0] prog;
	logic [3:0] fault;
	logic [7:0] addr_reg;
	result_t    expected_actions[$];
	result_t    got;
	result_t    want;
	int         fail_cnt;

	function automatic void store_received(input logic [7:0] data, inout result_t r);
		if (rd_idx < MAX_MESSAGE) begin
			msg_mem[rd_idx[AW-1:0]] = data;
			r.rx_byte = data;
			r.rx_store = 1'b1;
		end
	endfunction

	function automatic result_t next_bus_action(input logic [1:0] kind, input logic [7:0] data,
		input logic [5:0] mlen, input logic [3:0] code);
		result_t r;
		r = '0;
		case (kind)
		KIND_LOAD: begin
			if (wr_ptr < MAX_MESSAGE) begin
				msg_mem[wr_ptr[AW-1:0]] = data;
				wr_ptr = wr_ptr + 6'd1;
			end
		end
		KIND_BEGIN: begin
			xfer_len = (mlen > MAX_MESSAGE) ? 6'(MAX_MESSAGE) : mlen;
			wr_ptr = '0;
			prog = PROG_BUSY;
			r.go_start = 1'b1;
			r.irq_enable = 1'b1;
			r.clear_flag = 1'b1;
		end
		KIND_STATUS: begin
			case (code)
			ST_START, ST_RESTART: begin
				rd_idx = '0;
				r.tx_byte = addr_reg;
				r.tx_load = 1'b1;
				r.irq_enable = 1'b1;
				r.clear_flag = 1'b1;
			end
			ST_TXADDR_ACK, ST_TXDATA_ACK: begin
				if (rd_idx < xfer_len && rd_idx < MAX_MESSAGE) begin
					r.tx_byte = msg_mem[rd_idx[AW-1:0]];
					rd_idx = rd_idx + 6'd1;
					r.tx_load = 1'b1;
					r.irq_enable = 1'b1;
					r.clear_flag = 1'b1;
				end else begin
					prog = PROG_OK;
					r.go_stop = 1'b1;
					r.clear_flag = 1'b1;
				end
			end
			ST_RXDATA_ACK, ST_RXADDR_ACK: begin
				if (code == ST_RXDATA_ACK) begin
					store_received(data, r);
					if (rd_idx < MAX_MESSAGE)
						rd_idx = rd_idx + 6'd1;
				end
				r.send_ack = ({1'b0, rd_idx} + 7'd1 < {1'b0, xfer_len});
				r.irq_enable = 1'b1;
				r.clear_flag = 1'b1;
			end
			ST_RXDATA_NACK: begin
				store_received(data, r);
				prog = PROG_OK;
				r.go_stop = 1'b1;
				r.clear_flag = 1'b1;
			end
			default: begin
				prog = PROG_ERR;
				fault = (code > ST_OTHER) ? ST_OTHER : code;
			end
			endcase
		end
		default: ;
		endcase
		r.xfer_state = prog;
		r.fault_code = fault;
		return r;
	endfunction

	function automatic result_t unpack_result(input logic [31:0] d);
		result_t r;
		r.tx_byte = d[7:0];
		r.tx_load = d[8];
		r.go_start = d[9];
		r.go_stop = d[10];
		r.send_ack = d[11];
		r.irq_enable = d[12];
		r.clear_flag = d[13];
		r.xfer_state = d[15:14];
		r.fault_code = d[19:16];
		r.rx_byte = d[27:20];
		r.rx_store = d[28];
		return r;
	endfunction

	function automatic string describe(input result_t r);
		return $sformatf("tx %h/%b start %b stop %b ack %b irq %b clr %b state %0d fault %0d rx %h/%b",
			r.tx_byte, r.tx_load, r.go_start, r.go_stop, r.send_ack, r.irq_enable, r.clear_flag,
			r.xfer_state, r.fault_code, r.rx_byte, r.rx_store);
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			rd_idx = '0;
			wr_ptr = '0;
			xfer_len = '0;
			prog = PROG_IDLE;
			fault = '0;
			addr_reg = '0;
			expected_actions.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				got = unpack_result(m_tdata);
				if (expected_actions.size() == 0) begin
					if (fail_cnt < 10)
						$display("unexpected result transaction: %s", describe(got));
					fail_cnt++;
				end else begin
					want = expected_actions.pop_front();
					if (got.tx_byte !== want.tx_byte || got.tx_load !== want.tx_load ||
						got.go_start !== want.go_start || got.go_stop !== want.go_stop ||
						got.send_ack !== want.send_ack || got.irq_enable !== want.irq_enable ||
						got.clear_flag !== want.clear_flag || got.xfer_state !== want.xfer_state ||
						got.fault_code !== want.fault_code || got.rx_byte !== want.rx_byte ||
						got.rx_store !== want.rx_store) begin
						if (fail_cnt < 10)
							$display("mismatch: expected %s\n          got      %s",
								describe(want), describe(got));
						fail_cnt++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				addr_reg = cfg_data;
			if (s_tvalid && s_tready)
				expected_actions.push_back(next_bus_action(s_tuser, s_tdata[7:0], s_tdata[13:8],
					s_tdata[17:14]));
		end
		pending <= expected_actions.size();
		fails <= fail_cnt;
	end

endmodule

[tb/tb_i2c_master_transfer_sequencer.sv]
// Testbench top for the I2C master transfer sequencer: drives address writes and input
// transactions with random idle gaps and result stalls, and reports the verdict.
// Depends on i2cms_pkg, the sequencer RTL and i2cms_checker.

module tb_i2c_master_transfer_sequencer;
	import i2cms_pkg::*;

	localparam logic [1:0] KIND_NONE      = 2'd3;
	localparam logic [3:0] ST_TXADDR_NACK = 4'd7;
	localparam logic [3:0] ST_RXADDR_NACK = 4'd8;
	localparam logic [3:0] ST_TXDATA_NACK = 4'd9;
	localparam logic [3:0] ST_BUS_ERROR   = 4'd10;
	localparam logic [3:0] ST_HIGHEST     = 4'd15;
	localparam logic [5:0] LEN_FIELD_MAX  = 6'd63;
	localparam int         CYCLE_LIMIT    = 800000;
	localparam int         ITEM_TARGET    = 1750;
	localparam int         PHASES         = 6;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic [7:0]  cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic [23:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tready = 1'b0;
	wire logic        cfg_ready;
	wire logic        s_tready;
	wire logic        m_tvalid;
	wire logic [31:0] m_tdata;
	int pending;
	int fails;
	int sent;
	int cycles;
	int hold_cnt;
	int stall_len;
	bit calm;

	initial begin
		forever #6 clk = ~clk;
	end

	i2c_master_transfer_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	i2cms_checker action_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.pending   (pending),
		.fails     (fails)
	);

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
		end else if (m_tready) begin
			stall_len = gap_len();
			if (stall_len != 0) begin
				m_tready <= 1'b0;
				hold_cnt <= stall_len - 1;
			end else begin
				hold_cnt <= $urandom_range(0, 7);
			end
		end else begin
			m_tready <= 1'b1;
			hold_cnt <= $urandom_range(0, 7);
		end
	end

	task automatic send_item(input logic [1:0] kind, input logic [7:0] data,
		input logic [5:0] mlen, input logic [3:0] code);
		int gap;
		gap = gap_len();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {6'd0, code, mlen, data};
		do @(posedge clk); while (!s_tready);
		if (kind != KIND_NONE)
			sent++;
	endtask

	task automatic load_byte(input logic [7:0] data);
		send_item(KIND_LOAD, data, 6'($urandom_range(0, 63)),
			4'($urandom_range(ST_START, ST_HIGHEST)));
	endtask

	task automatic start_transfer(input logic [5:0] len);
		send_item(KIND_BEGIN, 8'($urandom_range(0, 255)), len,
			4'($urandom_range(ST_START, ST_HIGHEST)));
	endtask

	task automatic status_event(input logic [3:0] code, input logic [7:0] data);
		send_item(KIND_STATUS, data, 6'($urandom_range(0, 63)), code);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_address(input logic [7:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_transfer();
		int r;
		int n;
		int len;
		int used;
		r = $urandom_range(0, 99);
		n = $urandom_range(0, 99);
		len = (n < 70) ? $urandom_range(0, 6) : (n < 92) ? $urandom_range(7, 32) :
			$urandom_range(33, LEN_FIELD_MAX);
		used = (len > MAX_MESSAGE_DEF) ? MAX_MESSAGE_DEF : len;
		if (r < 40) begin
			n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : used;
			repeat (n) load_byte(8'($urandom_range(0, 255)));
			start_transfer(6'(len));
			status_event($urandom_range(0, 1) ? ST_START : ST_RESTART,
				8'($urandom_range(0, 255)));
			status_event(ST_TXADDR_ACK, 8'($urandom_range(0, 255)));
			for (int i = 0; i <= used; i++) begin
				if ($urandom_range(0, 29) == 0) begin
					status_event(4'($urandom_range(ST_TXADDR_NACK, ST_HIGHEST)),
						8'($urandom_range(0, 255)));
					break;
				end
				status_event(ST_TXDATA_ACK, 8'($urandom_range(0, 255)));
			end
		end else if (r < 75) begin
			start_transfer(6'(len));
			status_event($urandom_range(0, 1) ? ST_START : ST_RESTART,
				8'($urandom_range(0, 255)));
			status_event(ST_RXADDR_ACK, 8'($urandom_range(0, 255)));
			n = (used == 0) ? 0 : used - 1;
			if ($urandom_range(0, 7) == 0)
				n = used + $urandom_range(1, 6);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 29) == 0) begin
					status_event(4'($urandom_range(ST_TXADDR_NACK, ST_HIGHEST)),
						8'($urandom_range(0, 255)));
					break;
				end
				status_event(ST_RXDATA_ACK, 8'($urandom_range(0, 255)));
			end
			status_event(ST_RXDATA_NACK, 8'($urandom_range(0, 255)));
		end else if (r < 90) begin
			repeat ($urandom_range(1, 6))
				send_item(($urandom_range(0, 9) == 0) ? KIND_NONE :
					2'($urandom_range(KIND_LOAD, KIND_STATUS)), 8'($urandom_range(0, 255)),
					6'($urandom_range(0, 63)), 4'($urandom_range(ST_START, ST_HIGHEST)));
		end else begin
			start_transfer(6'(len));
			status_event(ST_START, 8'($urandom_range(0, 255)));
			status_event(4'($urandom_range(ST_TXADDR_NACK, ST_HIGHEST)),
				8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		int goal;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		write_address(8'hA4);

		// Every buffer entry is written once up front, so later sends never read an entry that was never written.
		for (int i = 0; i < MAX_MESSAGE_DEF; i++)
			load_byte((i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom_range(0, 255)));
		load_byte(8'h5A);

		start_transfer(6'd3);
		status_event(ST_START, 8'h00);
		status_event(ST_TXADDR_ACK, 8'h00);
		repeat (3) status_event(ST_TXDATA_ACK, 8'hFF);
		status_event(ST_TXDATA_ACK, 8'h00);
		start_transfer(LEN_FIELD_MAX);
		status_event(ST_RESTART, 8'hFF);
		status_event(ST_TXADDR_NACK, 8'h00);
		start_transfer(6'd2);
		status_event(ST_START, 8'h00);
		status_event(ST_RXADDR_ACK, 8'h00);
		status_event(ST_RXDATA_ACK, 8'hFF);
		status_event(ST_RXDATA_NACK, 8'h00);
		start_transfer(6'd0);
		status_event(ST_RXADDR_ACK, 8'hFF);
		status_event(ST_RXADDR_NACK, 8'hFF);
		status_event(ST_TXDATA_NACK, 8'h00);
		status_event(ST_BUS_ERROR, 8'hFF);
		status_event(ST_OTHER, 8'h00);
		status_event(ST_HIGHEST, 8'hFF);
		send_item(KIND_NONE, 8'hFF, LEN_FIELD_MAX, ST_HIGHEST);

		for (int p = 0; p < PHASES; p++) begin
			write_address((p == 0) ? 8'h00 : (p == 1) ? 8'hFF : 8'($urandom_range(0, 255)));
			calm = (p == 2);
			goal = sent + ITEM_TARGET / PHASES;
			while (sent < goal)
				random_transfer();
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[filelist.f]
hdl/i2cms_pkg.sv
hdl/i2cms_msg_buffer.sv
hdl/i2c_master_transfer_sequencer.sv
tb/i2cms_checker.sv
tb/tb_i2c_master_transfer_sequencer.sv
